>>> sv/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types, widths and the arctangent table for the decomposition core.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int SQ_STAGES = 32;
  localparam int OPW       = 33;
  localparam int CW        = 61;
  localparam int ZW        = 32;

  typedef struct packed {
    logic signed [OPW-1:0] y;
    logic signed [OPW-1:0] x;
  } vec_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> sv/afd_delay.sv
// ----------------------------------------------------------------------------
// afd_delay
// Fixed-depth register line that carries side data along the pipeline.
// ----------------------------------------------------------------------------
module afd_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < D; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[D-1];

endmodule

>>> sv/afd_sqrt.sv
// ----------------------------------------------------------------------------
// afd_sqrt
// Four-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module afd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] val [4],
  output logic        out_valid,
  output logic [31:0] root [4]
);

  localparam int N  = afd_pkg::SQ_STAGES;
  localparam int RW = 35;

  logic          vld [N+1];
  logic [63:0]   rad [4][N+1];
  logic [RW-1:0] rem [4][N+1];
  logic [31:0]   rt  [4][N+1];

  assign vld[0] = in_valid;

  for (genvar l = 0; l < 4; l++) begin : g_init
    assign rad[l][0] = val[l];
    assign rem[l][0] = '0;
    assign rt[l][0]  = '0;
    assign root[l]   = rt[l][N];
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [RW-1:0] r2;
      logic [RW-1:0] trial;
      assign r2    = {rem[l][k][RW-3:0], rad[l][k][63:62]};
      assign trial = {1'b0, rt[l][k], 2'b01};
      always_ff @(posedge clk) begin
        rad[l][k+1] <= {rad[l][k][61:0], 2'b00};
        if (r2 >= trial) begin
          rem[l][k+1] <= r2 - trial;
          rt[l][k+1]  <= {rt[l][k][30:0], 1'b1};
        end else begin
          rem[l][k+1] <= r2;
          rt[l][k+1]  <= {rt[l][k][30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];

endmodule

>>> sv/afd_cordic.sv
// ----------------------------------------------------------------------------
// afd_cordic
// Three-lane pipelined vectoring CORDIC arctangent with binary angle output.
// ----------------------------------------------------------------------------
module afd_cordic #(
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  afd_pkg::vec_t       vin [3],
  output logic                out_valid,
  output logic signed [15:0]  ang [3]
);

  localparam int CW = afd_pkg::CW;
  localparam int ZW = afd_pkg::ZW;
  localparam int OW = afd_pkg::OPW;

  logic                 vld [STAGES+2];
  logic signed [CW-1:0] xs  [3][STAGES+1];
  logic signed [CW-1:0] ys  [3][STAGES+1];
  logic [ZW-1:0]        zs  [3][STAGES+1];
  logic                 sp  [3][STAGES+1];
  logic [15:0]          spc [3][STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_pre
    logic signed [CW-1:0] xw;
    logic signed [CW-1:0] yw;
    assign xw = {{(CW-OW-24){vin[l].x[OW-1]}}, vin[l].x, 24'd0};
    assign yw = {{(CW-OW-24){vin[l].y[OW-1]}}, vin[l].y, 24'd0};
    always_ff @(posedge clk) begin
      sp[l][0] <= (vin[l].y == '0) || (vin[l].x == '0);
      if (vin[l].y == '0) begin
        spc[l][0] <= vin[l].x[OW-1] ? 16'h8000 : 16'h0000;
      end else begin
        spc[l][0] <= vin[l].y[OW-1] ? 16'hC000 : 16'h4000;
      end
      if (xw[CW-1] && !yw[CW-1]) begin
        xs[l][0] <= yw;
        ys[l][0] <= -xw;
        zs[l][0] <= 32'h40000000;
      end else if (xw[CW-1]) begin
        xs[l][0] <= -yw;
        ys[l][0] <= xw;
        zs[l][0] <= 32'hC0000000;
      end else begin
        xs[l][0] <= xw;
        ys[l][0] <= yw;
        zs[l][0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [ZW-1:0] a;
      assign a = afd_pkg::atan_entry(5'(i));
      always_ff @(posedge clk) begin
        sp[l][i+1]  <= sp[l][i];
        spc[l][i+1] <= spc[l][i];
        if (!ys[l][i][CW-1]) begin
          xs[l][i+1] <= xs[l][i] + (ys[l][i] >>> i);
          ys[l][i+1] <= ys[l][i] - (xs[l][i] >>> i);
          zs[l][i+1] <= zs[l][i] + a;
        end else begin
          xs[l][i+1] <= xs[l][i] - (ys[l][i] >>> i);
          ys[l][i+1] <= ys[l][i] + (xs[l][i] >>> i);
          zs[l][i+1] <= zs[l][i] - a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[STAGES+1] <= 1'b0;
    end else begin
      vld[STAGES+1] <= vld[STAGES];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [ZW-1:0] w;
    assign w = zs[l][STAGES] + 32'h00008000;
    always_ff @(posedge clk) begin
      ang[l] <= sp[l][STAGES] ? spc[l][STAGES] : w[31:16];
    end
  end

  assign out_valid = vld[STAGES+1];

endmodule

>>> sv/affine_matrix_decompose_euler_core.sv
// ----------------------------------------------------------------------------
// affine_matrix_decompose_euler_core
// Splits an affine transform into translation, column scales and Euler angles.
// ----------------------------------------------------------------------------
// channel  signals                         handshake
// in       m00..m32                        start, busy (busy stays low)
// out      tx ty tz sx sy sz rx ry rz      done, one cycle per transaction
//
// One transaction enters per cycle; each result passes through the square
// and sum registers, 32 root stages, then the CORDIC prerotation,
// CORDIC_STAGES micro-rotations and rounding.
// Reset clears only the valid bits. The receiver cannot stall, so nothing holds.
module affine_matrix_decompose_euler_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] m00,
  input  logic signed [31:0] m01,
  input  logic signed [31:0] m02,
  input  logic signed [31:0] m10,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m20,
  input  logic signed [31:0] m21,
  input  logic signed [31:0] m22,
  input  logic signed [31:0] m30,
  input  logic signed [31:0] m31,
  input  logic signed [31:0] m32,
  output logic               done,
  output logic signed [31:0] tx,
  output logic signed [31:0] ty,
  output logic signed [31:0] tz,
  output logic [30:0]        sx,
  output logic [30:0]        sy,
  output logic [30:0]        sz,
  output logic signed [15:0] rx,
  output logic signed [15:0] ry,
  output logic signed [15:0] rz
);

  localparam int OW  = afd_pkg::OPW;
  localparam int CL  = CORDIC_STAGES + 2;
  localparam int LAT = 2 + afd_pkg::SQ_STAGES + CL;
  localparam int SW  = 96 + 5 * OW;

  logic               v1;
  logic               v2;
  logic [63:0]        sq [9];
  logic [63:0]        sums [4];
  logic [SW-1:0]      side1;
  logic [SW-1:0]      side2;
  logic [SW-1:0]      side3;
  logic               sq_valid;
  logic [31:0]        roots [4];
  afd_pkg::vec_t      vin [3];
  logic signed [15:0] ang [3];
  logic [30:0]        sat [3];
  logic [95:0]        tr_d;
  logic [92:0]        sc_d;
  logic [31:0]        mag [9];
  logic               ca0;
  logic signed [OW-1:0] rx_y;
  logic signed [OW-1:0] rx_x;
  logic signed [OW-1:0] rz_y;
  logic signed [OW-1:0] rz_x;
  logic signed [OW-1:0] ry_y;

  assign busy = 1'b0;

  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    mag[0] = absv(m00);
    mag[1] = absv(m10);
    mag[2] = absv(m20);
    mag[3] = absv(m01);
    mag[4] = absv(m11);
    mag[5] = absv(m21);
    mag[6] = absv(m02);
    mag[7] = absv(m12);
    mag[8] = absv(m22);
    ca0    = (m00 == '0) && (m01 == '0);
    ry_y   = -OW'(m02);
    rx_y   = ca0 ? '0 : OW'(m12);
    rx_x   = ca0 ? '0 : OW'(m22);
    rz_y   = ca0 ? -OW'(m10) : OW'(m01);
    rz_x   = ca0 ? OW'(m11) : OW'(m00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      sq[i] <= mag[i] * mag[i];
    end
    side1   <= {m30, m31, m32, ry_y, rx_y, rx_x, rz_y, rz_x};
    sums[0] <= sq[0] + sq[1] + sq[2];
    sums[1] <= sq[3] + sq[4] + sq[5];
    sums[2] <= sq[6] + sq[7] + sq[8];
    sums[3] <= sq[0] + sq[3];
    side2   <= side1;
  end

  afd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .val       (sums),
    .out_valid (sq_valid),
    .root      (roots)
  );

  afd_delay #(.W(SW), .D(afd_pkg::SQ_STAGES)) u_side_dly (
    .clk  (clk),
    .din  (side2),
    .dout (side3)
  );

  always_comb begin
    vin[0].y = side3[4*OW-1:3*OW];
    vin[0].x = side3[3*OW-1:2*OW];
    vin[1].y = side3[5*OW-1:4*OW];
    vin[1].x = {1'b0, roots[3]};
    vin[2].y = side3[2*OW-1:OW];
    vin[2].x = side3[OW-1:0];
    for (int l = 0; l < 3; l++) begin
      sat[l] = roots[l][31] ? 31'h7FFFFFFF : roots[l][30:0];
    end
  end

  afd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .vin       (vin),
    .out_valid (done),
    .ang       (ang)
  );

  afd_delay #(.W(96), .D(CL)) u_tr_dly (
    .clk  (clk),
    .din  (side3[SW-1:SW-96]),
    .dout (tr_d)
  );

  afd_delay #(.W(93), .D(CL)) u_sc_dly (
    .clk  (clk),
    .din  ({sat[0], sat[1], sat[2]}),
    .dout (sc_d)
  );

  assign tx = tr_d[95:64];
  assign ty = tr_d[63:32];
  assign tz = tr_d[31:0];
  assign sx = sc_d[92:62];
  assign sy = sc_d[61:31];
  assign sz = sc_d[30:0];
  assign rx = ang[0];
  assign ry = ang[1];
  assign rz = ang[2];

`ifndef ASSERT_OFF
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after fixed latency");

  a_cordic_lat : assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> ##CL done)
    else $error("angle pipeline lost a transaction");

  a_zero_ca : assert property (@(posedge clk) disable iff (rst)
    (done && sx == '0 && sy == '0) |->
      (rx == '0 && (ry == 16'sh0000 || ry == 16'sh4000 || ry == -16'sh4000)))
    else $error("degenerate column angles wrong");
`endif

endmodule

>>> test/affine_matrix_decompose_euler_core_tb.sv
// ----------------------------------------------------------------------------
// affine_matrix_decompose_euler_core_tb
// Drives affine transforms into the decomposition core and checks every result
// against set values or a bit-exact model of the norms and CORDIC arctangents.
// ----------------------------------------------------------------------------
module affine_matrix_decompose_euler_core_tb;

  localparam int STAGES    = 16;
  localparam int N_RANDOM  = 1700;
  localparam int LATENCY   = 36 + STAGES;

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, m30, m31, m32;
  } xform_t;

  typedef struct packed {
    logic signed [31:0] tx, ty, tz;
    logic [30:0]        sx, sy, sz;
    logic signed [15:0] rx, ry, rz;
  } decomp_t;

  typedef struct {
    xform_t  m;
    bit      known;
    decomp_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  xform_t cur = '0;
  decomp_t got;

  decomp_t pending[$];
  int errors = 0;
  int rows_n;
  row_t rows[32];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  affine_matrix_decompose_euler_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(cur.m00), .m01(cur.m01), .m02(cur.m02),
    .m10(cur.m10), .m11(cur.m11), .m12(cur.m12),
    .m20(cur.m20), .m21(cur.m21), .m22(cur.m22),
    .m30(cur.m30), .m31(cur.m31), .m32(cur.m32),
    .done(done), .tx(got.tx), .ty(got.ty), .tz(got.tz),
    .sx(got.sx), .sy(got.sy), .sz(got.sz),
    .rx(got.rx), .ry(got.ry), .rz(got.rz)
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_sq(longint v);
    logic [63:0] a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  function automatic logic [30:0] col_scale(longint a, longint b, longint c);
    logic [63:0] r;
    r = int_sqrt(mag_sq(a) + mag_sq(b) + mag_sq(c));
    return (r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r[30:0];
  endfunction

  function automatic logic [15:0] bin_atan2(longint y, longint x);
    longint z, xn, yn, a;
    logic [31:0] w;
    if (y == 0) return (x >= 0) ? 16'h0000 : 16'h8000;
    if (x == 0) return (y > 0) ? 16'h4000 : 16'hC000;
    x = x <<< 24;
    y = y <<< 24;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        xn = y; yn = -x; z = 64'sh40000000;
      end else begin
        xn = -y; yn = x; z = -64'sh40000000;
      end
      x = xn; y = yn;
    end
    for (int i = 0; i < STAGES; i++) begin
      a = afd_pkg::atan_entry(i[4:0]);
      if (y >= 0) begin
        xn = x + (y >>> i); yn = y - (x >>> i); z = z + a;
      end else begin
        xn = x - (y >>> i); yn = y + (x >>> i); z = z - a;
      end
      x = xn; y = yn;
    end
    w = z[31:0] + 32'h8000;
    return w[31:16];
  endfunction

  function automatic decomp_t decompose(xform_t m);
    decomp_t r;
    longint ca;
    r.tx = m.m30; r.ty = m.m31; r.tz = m.m32;
    r.sx = col_scale(m.m00, m.m10, m.m20);
    r.sy = col_scale(m.m01, m.m11, m.m21);
    r.sz = col_scale(m.m02, m.m12, m.m22);
    ca = int_sqrt(mag_sq(m.m00) + mag_sq(m.m01));
    r.ry = bin_atan2(-longint'(m.m02), ca);
    if (ca == 0) begin
      r.rx = 0;
      r.rz = bin_atan2(-longint'(m.m10), m.m11);
    end else begin
      r.rx = bin_atan2(m.m12, m.m22);
      r.rz = bin_atan2(m.m01, m.m00);
    end
    return r;
  endfunction

  task automatic report(string what, longint g, longint e);
    $display("mismatch %s: got %0h expected %0h", what, g, e);
    errors++;
  endtask

  always @(posedge clk) begin
    decomp_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        e = pending.pop_front();
        if (got.tx !== e.tx) report("tx", got.tx, e.tx);
        if (got.ty !== e.ty) report("ty", got.ty, e.ty);
        if (got.tz !== e.tz) report("tz", got.tz, e.tz);
        if (got.sx !== e.sx) report("sx", got.sx, e.sx);
        if (got.sy !== e.sy) report("sy", got.sy, e.sy);
        if (got.sz !== e.sz) report("sz", got.sz, e.sz);
        if (got.rx !== e.rx) report("rx", got.rx, e.rx);
        if (got.ry !== e.ry) report("ry", got.ry, e.ry);
        if (got.rz !== e.rz) report("rz", got.rz, e.rz);
      end
    end
  end

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      4, 5: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'h1FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic xform_t rnd_xform();
    xform_t m;
    m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      m.m00 = rnd_elem(); m.m01 = rnd_elem(); m.m02 = rnd_elem();
      m.m10 = rnd_elem(); m.m11 = rnd_elem(); m.m12 = rnd_elem();
      m.m20 = rnd_elem(); m.m21 = rnd_elem(); m.m22 = rnd_elem();
    end
    if ($urandom_range(0, 7) == 0) begin
      m.m00 = 0; m.m01 = 0;
    end
    return m;
  endfunction

  task automatic send(xform_t m, decomp_t e);
    start <= 1'b1;
    cur <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(e);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic row_t mk(xform_t m, bit known, decomp_t r);
    row_t t;
    t.m = m; t.known = known; t.r = r;
    return t;
  endfunction

  initial begin
    xform_t m;
    decomp_t e;
    int idle;
    rows_n = 0;
    rows[rows_n] = mk('0, 1, '0); rows_n++;
    m = '0; m.m30 = 32'h80000000; m.m31 = 32'h7FFFFFFF; m.m32 = 32'hFFFFFFFF;
    m.m00 = 32'h00010000; m.m11 = 32'h00010000; m.m22 = 32'h00010000;
    e = '0; e.tx = 32'h80000000; e.ty = 32'h7FFFFFFF; e.tz = 32'hFFFFFFFF;
    e.sx = 31'h10000; e.sy = 31'h10000; e.sz = 31'h10000;
    rows[rows_n] = mk(m, 1, e); rows_n++;
    m = '0; m.m00 = 32'h80000000; m.m10 = 32'h80000000; m.m20 = 32'h80000000;
    e = '0; e.sx = 31'h7FFFFFFF; e.rz = 16'sh8000;
    rows[rows_n] = mk(m, 1, e); rows_n++;
    m = '0; m.m01 = 32'h7FFFFFFF; m.m02 = 32'h7FFFFFFF; m.m21 = 32'h7FFFFFFF;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '0; m.m02 = 32'h00010000; m.m10 = 32'h00010000;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '0; m.m02 = 32'hFFFF0000; m.m11 = 32'hFFFF0000;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '0; m.m11 = 32'h00010000; m.m10 = 32'h80000000;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '1;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = {12{32'h80000000}};
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = {12{32'h7FFFFFFF}};
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '0; m.m00 = 32'hFFFFFFFF; m.m12 = 32'h1; m.m22 = 32'hFFFFFFFF;
    rows[rows_n] = mk(m, 0, '0); rows_n++;
    m = '0; m.m00 = 32'h1; m.m01 = 32'hFFFFFFFF; m.m12 = 32'hFFFFFFFF;
    rows[rows_n] = mk(m, 0, '0); rows_n++;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < rows_n; i++)
      send(rows[i].m, rows[i].known ? rows[i].r : decompose(rows[i].m));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
      if (i < N_RANDOM - 200 && $urandom_range(0, 5) == 0) begin
        idle = $urandom_range(1, 11);
        pause(idle);
      end
      m = rnd_xform();
      send(m, decompose(m));
    end
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> affine_matrix_decompose_euler_core.f
sv/afd_pkg.sv
sv/afd_delay.sv
sv/afd_sqrt.sv
sv/afd_cordic.sv
sv/affine_matrix_decompose_euler_core.sv
test/affine_matrix_decompose_euler_core_tb.sv
